### rtl/hoare_partition_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for hoare_partition
// Implication checks, same cycle and next cycle, compiled out with ASSERT_OFF.
// ---------------------------------------------------------------------------
`ifndef HOARE_PARTITION_ASSERT_SVH
`define HOARE_PARTITION_ASSERT_SVH

`ifndef ASSERT_OFF
`define HP_ASSERT_IMP(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("hoare_partition: same-cycle check failed");
`define HP_ASSERT_NXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("hoare_partition: next-cycle check failed");
`else
`define HP_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define HP_ASSERT_NXT(name, clk, rst_n, ante, cons)
`endif

`endif

### rtl/hp_pkg.sv
// ---------------------------------------------------------------------------
// hp_pkg
// Data types shared by the Hoare partition block.
// ---------------------------------------------------------------------------
package hp_pkg;

	localparam int DATA_W = 32;

	typedef logic signed [DATA_W-1:0] data_t;

endpackage

### rtl/hoare_partition.sv
// ---------------------------------------------------------------------------
// hoare_partition
// Loads a signed array into a local memory, partitions it around a pivot by
// the Hoare scheme and streams the rearranged array out.
// ---------------------------------------------------------------------------
// Input: a beat is taken on a rising edge with start high and busy low. Each
// beat stores value; the beat with last high also samples pivot and begins
// the partition. Elements beyond MAX_ELEMENTS are dropped. Loading takes
// one element per cycle.
// Partition: all work goes through one memory with one read and one write
// port and a registered read. Each pass reads the left element; the left
// scan steps up past elements below the pivot, the right scan down past
// elements above it, and a swap exchanges the two. busy is high throughout.
// Output: n result beats, one per cycle on consecutive cycles, each marked
// by strobe; end_of_run marks the final one. The beats come from registered
// memory reads issued in the emit state that follows the partition. The
// receiver cannot stall, so nothing is held back. The block is ready for
// a new array when busy falls, on the cycle the final beat is shown.
// Reset clears the element count and the state; the memory is not cleared,
// since only entries written in the current run are ever read.
// ---------------------------------------------------------------------------
`include "hoare_partition_assert.svh"

module hoare_partition #(
	parameter int MAX_ELEMENTS = 64,
	localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1,
	localparam int CW = $clog2(MAX_ELEMENTS + 1)
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  hp_pkg::data_t   value,
	input  hp_pkg::data_t   pivot,
	input  logic            last,
	output logic            strobe,
	output hp_pkg::data_t   element,
	output logic            is_low,
	output logic [CW-1:0]   low_count,
	output logic            end_of_run
);

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_LREAD,
		ST_LSCAN,
		ST_RSCAN,
		ST_SWAP,
		ST_EMIT
	} state_t;

	state_t          state_q;
	logic [CW-1:0]   count_q;
	logic [AW-1:0]   lo_q;
	logic [AW-1:0]   hi_q;
	logic [AW-1:0]   last_idx_q;
	logic [AW-1:0]   k_q;
	hp_pkg::data_t   pivot_q;
	hp_pkg::data_t   vlo_q;
	hp_pkg::data_t   rd_q;
	logic            strobe_q;
	logic            is_low_q;
	logic            end_q;
	logic [CW-1:0]   low_count_q;

	hp_pkg::data_t   mem [MAX_ELEMENTS];

	logic            mem_we;
	logic [AW-1:0]   mem_waddr;
	hp_pkg::data_t   mem_wdata;
	logic            mem_re;
	logic [AW-1:0]   mem_raddr;

	logic            full;
	logic [CW-1:0]   n_next;
	logic            l_adv;
	logic            r_step;
	logic            crossed;

	assign full    = (count_q == CW'(MAX_ELEMENTS));
	assign n_next  = full ? count_q : count_q + CW'(1);
	// The left scan halts at the final position, the right scan at zero.
	assign l_adv   = (lo_q != last_idx_q) && (rd_q < pivot_q);
	assign r_step  = (hi_q != '0) && (rd_q > pivot_q);
	assign crossed = (lo_q >= hi_q);

	assign busy       = (state_q != ST_LOAD);
	assign strobe     = strobe_q;
	assign element    = rd_q;
	assign is_low     = is_low_q;
	assign low_count  = low_count_q;
	assign end_of_run = end_q;

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = count_q[AW-1:0];
		mem_wdata = value;
		mem_re    = 1'b0;
		mem_raddr = lo_q;
		unique case (state_q)
			ST_LOAD: begin
				mem_we = start && !full;
			end
			ST_LREAD: begin
				mem_re = 1'b1;
			end
			ST_LSCAN: begin
				mem_re    = 1'b1;
				mem_raddr = l_adv ? lo_q + AW'(1) : hi_q;
			end
			ST_RSCAN: begin
				if (r_step) begin
					mem_re    = 1'b1;
					mem_raddr = hi_q - AW'(1);
				end else if (!crossed) begin
					// First half of the swap: the right element goes left.
					mem_we    = 1'b1;
					mem_waddr = lo_q;
					mem_wdata = rd_q;
				end
			end
			ST_SWAP: begin
				mem_we    = 1'b1;
				mem_waddr = hi_q;
				mem_wdata = vlo_q;
			end
			ST_EMIT: begin
				mem_re    = 1'b1;
				mem_raddr = k_q;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_q <= mem[mem_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			count_q     <= '0;
			lo_q        <= '0;
			hi_q        <= '0;
			last_idx_q  <= '0;
			k_q         <= '0;
			pivot_q     <= '0;
			vlo_q       <= '0;
			strobe_q    <= 1'b0;
			is_low_q    <= 1'b0;
			end_q       <= 1'b0;
			low_count_q <= '0;
		end else begin
			strobe_q <= (state_q == ST_EMIT);
			unique case (state_q)
				ST_LOAD: begin
					if (start) begin
						if (last) begin
							pivot_q    <= pivot;
							lo_q       <= '0;
							hi_q       <= AW'(n_next - CW'(1));
							last_idx_q <= AW'(n_next - CW'(1));
							count_q    <= '0;
							state_q    <= ST_LREAD;
						end else begin
							count_q <= n_next;
						end
					end
				end
				ST_LREAD: begin
					state_q <= ST_LSCAN;
				end
				ST_LSCAN: begin
					if (l_adv) begin
						lo_q <= lo_q + AW'(1);
					end else begin
						vlo_q   <= rd_q;
						state_q <= ST_RSCAN;
					end
				end
				ST_RSCAN: begin
					if (r_step) begin
						hi_q <= hi_q - AW'(1);
					end else if (crossed) begin
						k_q     <= '0;
						state_q <= ST_EMIT;
					end else begin
						state_q <= ST_SWAP;
					end
				end
				ST_SWAP: begin
					lo_q <= lo_q + AW'(1);
					if (hi_q != '0) begin
						hi_q <= hi_q - AW'(1);
					end
					state_q <= ST_LREAD;
				end
				ST_EMIT: begin
					is_low_q    <= (k_q <= hi_q);
					end_q       <= (k_q == last_idx_q);
					low_count_q <= CW'(hi_q) + CW'(1);
					k_q         <= k_q + AW'(1);
					if (k_q == last_idx_q) begin
						state_q <= ST_LOAD;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	`HP_ASSERT_IMP(a_low_count_nonzero, clk, arst_n, strobe, low_count != '0)
	`HP_ASSERT_NXT(a_run_contiguous, clk, arst_n, strobe && !end_of_run, strobe)
	`HP_ASSERT_NXT(a_run_ends_clean, clk, arst_n, strobe && end_of_run, !strobe)
	`HP_ASSERT_IMP(a_hi_in_range, clk, arst_n, busy, hi_q <= last_idx_q && lo_q <= last_idx_q)

endmodule

### dv/tb_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// Testbench for hoare_partition. Loads signed arrays beat by beat, predicts
// the partitioned array with a bounded Hoare scheme of its own, and checks
// every result beat against the oldest prediction.
// ---------------------------------------------------------------------------
module tb_top;

	typedef hp_pkg::data_t data_t;

	localparam int MAX_ELEMENTS = 64;
	localparam data_t DATA_MIN = {1'b1, {(hp_pkg::DATA_W-1){1'b0}}};
	localparam data_t DATA_MAX = {1'b0, {(hp_pkg::DATA_W-1){1'b1}}};
	localparam int MAX_SHOWN = 10;

	typedef enum int {VAL_WIDE, VAL_NARROW, VAL_EDGE} value_mode_t;
	typedef enum int {PIV_WIDE, PIV_MEMBER, PIV_MIN, PIV_MAX, PIV_NARROW} pivot_mode_t;

	typedef struct {
		data_t value;
		data_t pivot;
		logic  last;
	} elem_beat_t;

	typedef struct {
		data_t      element;
		logic       is_low;
		logic [6:0] low_count;
		logic       end_of_run;
	} part_result_t;

	logic       clk;
	logic       arst_n;
	logic       start;
	logic       busy;
	data_t      value;
	data_t      pivot;
	logic       last;
	logic       strobe;
	data_t      element;
	logic       is_low;
	logic [6:0] low_count;
	logic       end_of_run;

	elem_beat_t   load_queue[$];
	part_result_t expected_parts[$];
	data_t        build_vals[$];

	data_t model_store[MAX_ELEMENTS];
	int    model_count = 0;
	int    err_count = 0;
	int    total_items = 0;
	int    burst_left;
	int    gap_left;

	hoare_partition #(
		.MAX_ELEMENTS(MAX_ELEMENTS)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.value      (value),
		.pivot      (pivot),
		.last       (last),
		.strobe     (strobe),
		.element    (element),
		.is_low     (is_low),
		.low_count  (low_count),
		.end_of_run (end_of_run)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#2ms;
		$display("tb_top: FAIL");
		$finish;
	end

	// Store one accepted element; on the last beat run the bounded Hoare
	// partition and queue one expected result per stored element.
	task automatic load_and_partition(input data_t v, input data_t pv, input logic lst);
		int lo;
		int hi;
		int n;
		bit first;
		data_t t;
		part_result_t r;
		if (model_count < MAX_ELEMENTS) begin
			model_store[model_count] = v;
			model_count++;
		end
		if (lst) begin
			n = model_count;
			if (n > 0) begin
				lo = 0;
				hi = n - 1;
				first = 1'b1;
				forever begin
					if (!first)
						lo++;
					while (lo < n - 1 && model_store[lo] < pv)
						lo++;
					if (!first && hi > 0)
						hi--;
					while (hi > 0 && model_store[hi] > pv)
						hi--;
					first = 1'b0;
					if (lo >= hi)
						break;
					t = model_store[lo];
					model_store[lo] = model_store[hi];
					model_store[hi] = t;
				end
				for (int k = 0; k < n; k++) begin
					r.element = model_store[k];
					r.is_low = (k <= hi);
					r.low_count = 7'(hi + 1);
					r.end_of_run = (k == n - 1);
					expected_parts.push_back(r);
				end
			end
			model_count = 0;
		end
	endtask

	task automatic note_mismatch(input string msg);
		err_count++;
		if (err_count <= MAX_SHOWN)
			$display("%0t: %s", $realtime, msg);
	endtask

	// Queue build_vals as one array; the pivot rides on the last beat and the
	// pivot field of earlier beats carries noise.
	task automatic push_array(input data_t pv);
		elem_beat_t b;
		for (int i = 0; i < build_vals.size(); i++) begin
			b.value = build_vals[i];
			b.last = (i == build_vals.size() - 1);
			b.pivot = b.last ? pv : data_t'($urandom);
			load_queue.push_back(b);
			total_items++;
		end
	endtask

	function automatic data_t rand_value(input value_mode_t mode);
		case (mode)
			VAL_NARROW: begin
				return data_t'(int'($urandom_range(0, 8)) - 4);
			end
			VAL_EDGE: begin
				case ($urandom_range(0, 4))
					0: return DATA_MIN;
					1: return DATA_MAX;
					2: return data_t'(0);
					3: return data_t'(-1);
					default: return data_t'($urandom);
				endcase
			end
			default: begin
				return data_t'($urandom);
			end
		endcase
	endfunction

	task automatic random_array(input int len);
		value_mode_t vmode;
		pivot_mode_t pmode;
		data_t pv;
		vmode = value_mode_t'($urandom_range(0, 2));
		pmode = pivot_mode_t'($urandom_range(0, 4));
		build_vals.delete();
		for (int i = 0; i < len; i++)
			build_vals.push_back(rand_value(vmode));
		case (pmode)
			PIV_MEMBER: pv = build_vals[$urandom_range(0, len - 1)];
			PIV_MIN:    pv = DATA_MIN;
			PIV_MAX:    pv = DATA_MAX;
			PIV_NARROW: pv = rand_value(VAL_NARROW);
			default:    pv = data_t'($urandom);
		endcase
		push_array(pv);
	endtask

	// Driver: inputs change on the falling edge, in bursts with random gaps.
	always @(negedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
			value <= '0;
			pivot <= '0;
			last <= 1'b0;
			burst_left <= 0;
			gap_left <= 0;
		end else if (gap_left > 0) begin
			start <= 1'b0;
			gap_left <= gap_left - 1;
		end else if (load_queue.size() > 0) begin
			start <= 1'b1;
			value <= load_queue[0].value;
			pivot <= load_queue[0].pivot;
			last <= load_queue[0].last;
			if (burst_left > 0) begin
				burst_left <= burst_left - 1;
			end else if ($urandom_range(0, 4) == 0) begin
				burst_left <= $urandom_range(40, 120);
				gap_left <= 0;
			end else begin
				burst_left <= $urandom_range(1, 20);
				gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			end
		end else begin
			start <= 1'b0;
		end
	end

	// Monitor: input beats and result beats are both taken on the rising edge.
	always @(posedge clk) begin : monitor
		part_result_t exp_r;
		if (arst_n) begin
			if (start && !busy) begin
				load_and_partition(value, pivot, last);
				load_queue.delete(0);
			end
			if (strobe) begin
				if (expected_parts.size() == 0) begin
					note_mismatch($sformatf("result beat with none expected: element %0d",
						element));
				end else begin
					exp_r = expected_parts.pop_front();
					if (element !== exp_r.element || is_low !== exp_r.is_low ||
							low_count !== exp_r.low_count ||
							end_of_run !== exp_r.end_of_run)
						note_mismatch($sformatf(
							"mismatch: exp el %0d low %b cnt %0d eor %b, got el %0d low %b cnt %0d eor %b",
							exp_r.element, exp_r.is_low, exp_r.low_count, exp_r.end_of_run,
							element, is_low, low_count, end_of_run));
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;

		// Directed arrays: a single element, a pivot below and above every
		// element, duplicates equal to the pivot, extremes, and a pivot that
		// is not a member.
		build_vals = {DATA_MAX};
		push_array(data_t'(0));
		build_vals = {data_t'(5), data_t'(3), data_t'(9)};
		push_array(DATA_MIN);
		build_vals = {DATA_MIN, data_t'(0), data_t'(-7)};
		push_array(DATA_MAX);
		build_vals = {data_t'(4), data_t'(4), data_t'(4), data_t'(4)};
		push_array(data_t'(4));
		build_vals = {DATA_MAX, DATA_MIN};
		push_array(data_t'(0));
		build_vals = {DATA_MAX, DATA_MIN, DATA_MAX, DATA_MIN, data_t'(0)};
		push_array(data_t'(0));
		build_vals = {data_t'(10), data_t'(-20), data_t'(30), data_t'(-40)};
		push_array(data_t'(5));

		// A full store, then an array that overflows it so the last two values drop.
		random_array(MAX_ELEMENTS);
		random_array(MAX_ELEMENTS + 2);
		while (total_items < 360) begin
			case ($urandom_range(0, 19))
				0: random_array(MAX_ELEMENTS);
				1: random_array($urandom_range(MAX_ELEMENTS + 1, MAX_ELEMENTS + 4));
				default: random_array($urandom_range(1, 12));
			endcase
		end

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (load_queue.size() != 0 || expected_parts.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (err_count == 0 && expected_parts.size() == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule

### hoare_partition.f
+incdir+rtl
rtl/hp_pkg.sv
rtl/hoare_partition.sv
dv/tb_top.sv
